// ===== rtl/efp_pkg.sv =====
// ----------------------------------------------------------------------------
// efp_pkg
// Shared types and constants of the event frame parser: transaction structs,
// frame phases, result status codes and register indexes.
// ----------------------------------------------------------------------------
package efp_pkg;

    localparam int POS_PAYLOAD_BYTES   = 20;
    localparam int LIGHT_PAYLOAD_BYTES = 4;
    localparam int TIME_BYTES          = 4;
    localparam int IDX_W               = $clog2(POS_PAYLOAD_BYTES);
    localparam int TIME_IDX_W          = $clog2(TIME_BYTES);
    localparam int CODE_W              = 8;
    localparam int CFG_INDEX_W         = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POSITION_CODE = 1'd0,
        CFG_LIGHT_CODE    = 1'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_TIME    = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DISCARD = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_POS     = 2'd0,
        ST_LIGHT   = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_TRUNC   = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [31:0]        time_ms;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
        logic signed [15:0] yaw;
        logic [7:0]         light_index;
        logic [23:0]        colour;
    } out_item_t;

endpackage

// ===== rtl/efp_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// efp_frame_fsm
// Frame state, timestamp and payload registers, and the single-pass logic
// that turns one accepted byte into the next state and an optional result.
// ----------------------------------------------------------------------------
module efp_frame_fsm (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  efp_pkg::in_item_t                 in_item,
    input  logic [efp_pkg::CODE_W-1:0]        position_code,
    input  logic [efp_pkg::CODE_W-1:0]        light_code,
    output logic                              res_valid,
    output efp_pkg::out_item_t                res_item
);
    import efp_pkg::*;

    localparam logic [IDX_W-1:0] POS_LAST   = IDX_W'(POS_PAYLOAD_BYTES - 1);
    localparam logic [IDX_W-1:0] LIGHT_LAST = IDX_W'(LIGHT_PAYLOAD_BYTES - 1);
    localparam logic [IDX_W-1:0] TIME_LAST  = IDX_W'(TIME_BYTES - 1);

    phase_t                       phase_reg, phase_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [CODE_W-1:0]            type_reg, type_next;
    logic                         kind_pos_reg, kind_pos_next;
    logic [TIME_BYTES-1:0][7:0]   time_acc_reg, time_acc_next;
    logic [7:0]                   payload_reg [POS_PAYLOAD_BYTES];
    logic                         pay_we;

    logic [7:0]                   b;
    logic                         last;
    logic [TIME_BYTES-1:0][7:0]   time_view;
    logic [7:0]                   view [POS_PAYLOAD_BYTES];
    logic                         type_is_pos;
    logic                         type_known;
    logic                         time_final;
    logic                         pay_final;

    assign b           = in_item.data_byte;
    assign last        = in_item.buffer_end;
    assign type_is_pos = (type_reg == position_code);
    assign type_known  = type_is_pos || (type_reg == light_code);
    assign time_final  = (idx_reg == TIME_LAST);
    assign pay_final   = (idx_reg == (kind_pos_reg ? POS_LAST : LIGHT_LAST));

    always_comb begin
        for (int j = 0; j < TIME_BYTES; j++) begin
            time_view[j] = (idx_reg[TIME_IDX_W-1:0] == TIME_IDX_W'(j)) ? b : time_acc_reg[j];
        end
        for (int i = 0; i < POS_PAYLOAD_BYTES; i++) begin
            view[i] = (idx_reg == IDX_W'(i)) ? b : payload_reg[i];
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        type_next     = type_reg;
        kind_pos_next = kind_pos_reg;
        time_acc_next = time_acc_reg;
        pay_we        = 1'b0;
        unique case (phase_reg)
            PH_TYPE: begin
                type_next     = b;
                time_acc_next = '0;
                idx_next      = '0;
                if (!last) begin
                    phase_next = PH_TIME;
                end
            end
            PH_TIME: begin
                time_acc_next = time_view;
                if (time_final) begin
                    idx_next      = '0;
                    kind_pos_next = type_is_pos;
                    if (last) begin
                        phase_next = PH_TYPE;
                    end else if (type_known) begin
                        phase_next = PH_PAYLOAD;
                    end else begin
                        phase_next = PH_DISCARD;
                    end
                end else if (last) begin
                    idx_next   = '0;
                    phase_next = PH_TYPE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            PH_PAYLOAD: begin
                pay_we = 1'b1;
                if (pay_final || last) begin
                    idx_next   = '0;
                    phase_next = PH_TYPE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            PH_DISCARD: begin
                if (last) begin
                    idx_next   = '0;
                    phase_next = PH_TYPE;
                end
            end
        endcase
    end

    always_comb begin
        res_valid = 1'b0;
        res_item  = '0;
        unique case (phase_reg)
            PH_TYPE: begin
                if (last) begin
                    res_valid       = 1'b1;
                    res_item.status = ST_TRUNC;
                end
            end
            PH_TIME: begin
                if (time_final && !type_known) begin
                    res_valid        = 1'b1;
                    res_item.status  = ST_UNKNOWN;
                    res_item.time_ms = time_view;
                end else if (last) begin
                    res_valid       = 1'b1;
                    res_item.status = ST_TRUNC;
                end
            end
            PH_PAYLOAD: begin
                if (pay_final) begin
                    res_valid        = 1'b1;
                    res_item.time_ms = time_acc_reg;
                    if (kind_pos_reg) begin
                        res_item.status = ST_POS;
                        res_item.pos_x  = {view[3], view[2], view[1], view[0]};
                        res_item.pos_y  = {view[7], view[6], view[5], view[4]};
                        res_item.pos_z  = {view[11], view[10], view[9], view[8]};
                        res_item.vel_x  = {view[13], view[12]};
                        res_item.vel_y  = {view[15], view[14]};
                        res_item.vel_z  = {view[17], view[16]};
                        res_item.yaw    = {view[19], view[18]};
                    end else begin
                        res_item.status      = ST_LIGHT;
                        res_item.light_index = view[0];
                        res_item.colour      = {view[1], view[2], view[3]};
                    end
                end else if (last) begin
                    res_valid       = 1'b1;
                    res_item.status = ST_TRUNC;
                end
            end
            PH_DISCARD: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TYPE;
            idx_reg      <= '0;
            type_reg     <= '0;
            kind_pos_reg <= 1'b1;
            time_acc_reg <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            type_reg     <= type_next;
            kind_pos_reg <= kind_pos_next;
            time_acc_reg <= time_acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && pay_we) begin
            payload_reg[idx_reg] <= b;
        end
    end

`ifndef ASSERT_OFF
    a_type_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TYPE) |-> (idx_reg == '0))
        else $error("byte index not cleared while awaiting a type byte");

    a_time_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TIME) |-> (idx_reg <= TIME_LAST))
        else $error("timestamp byte index out of range");

    a_pos_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (idx_reg <= POS_LAST))
        else $error("payload byte index out of range");

    a_light_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD && !kind_pos_reg) |-> (idx_reg <= LIGHT_LAST))
        else $error("light payload ran past its length");
`endif

endmodule

// ===== rtl/efp_out_stage.sv =====
// ----------------------------------------------------------------------------
// efp_out_stage
// Result register between the frame logic and the output channel. It takes
// a new result in the same cycle that the waiting one leaves.
// ----------------------------------------------------------------------------
module efp_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  efp_pkg::out_item_t  load_item,
    output logic                space,
    input  logic                m_ready,
    output logic                m_valid,
    output efp_pkg::out_item_t  m_data
);
    import efp_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    assign space      = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);
    assign m_valid    = valid_reg;
    assign m_data     = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_item;
        end
    end

`ifndef ASSERT_OFF
    a_load_has_space: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> space)
        else $error("result loaded over one that was not taken");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_valid && m_data == $past(load_item)))
        else $error("loaded result not presented");

    a_idle_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (!load && m_ready) |=> !m_valid)
        else $error("result presented twice");
`endif

endmodule

// ===== rtl/event_frame_parser.sv =====
// ----------------------------------------------------------------------------
// event_frame_parser
// Little-endian event frame parser: one byte per transaction in, one
// position, light, unknown-type or truncation record per frame out.
// ----------------------------------------------------------------------------
// The parser takes one byte in every clock cycle. Each byte updates the frame
// state in a single pass, and the record of a frame is loaded into a result
// register when its final byte is accepted. Input and output stall together
// only when a record waits in that register and the output is not ready. The
// user must write type codes on the configuration port only while no frame
// is in progress; the block does not enforce it. The codes reset to 1 and 2.
module event_frame_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  efp_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output efp_pkg::out_item_t              m_data,
    input  logic                            cfg_we,
    input  logic [efp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [efp_pkg::CODE_W-1:0]      cfg_wdata
);
    import efp_pkg::*;

    logic [CODE_W-1:0] position_code_reg;
    logic [CODE_W-1:0] light_code_reg;
    logic              accept;
    logic              res_valid;
    out_item_t         res_item;
    logic              space;

    assign s_ready = space;
    assign accept  = s_valid && space;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_code_reg <= CODE_W'(1);
            light_code_reg    <= CODE_W'(2);
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_POSITION_CODE: position_code_reg <= cfg_wdata;
                CFG_LIGHT_CODE:    light_code_reg    <= cfg_wdata;
            endcase
        end
    end

    efp_frame_fsm u_frame_fsm (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .in_item       (s_data),
        .position_code (position_code_reg),
        .light_code    (light_code_reg),
        .res_valid     (res_valid),
        .res_item      (res_item)
    );

    efp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept && res_valid),
        .load_item (res_item),
        .space     (space),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the event frame parser. A byte driver and a
// record monitor run on opposite clock edges with random stalls on both
// channels. Every accepted byte goes through a local frame decoder that
// queues the expected record, and each record from the parser is checked
// field by field against the oldest one. The run starts with directed
// frames and then sends random buffers under several type code settings.
// ----------------------------------------------------------------------------
module tb_top;
    import efp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 230;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CODE_W-1:0]      cfg_wdata;

    event_frame_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    in_item_t  byte_stream[$];
    out_item_t expected_records[$];
    int        n_queued;
    int        n_sent;
    int        n_taken;
    int        n_errors;
    int        n_cycles;
    int        n_records;
    int        status_count[4];
    bit        no_idle;

    logic [7:0] pos_code   = 8'd1;
    logic [7:0] light_code = 8'd2;

    phase_t      parse_phase = PH_TYPE;
    int          field_idx;
    logic [7:0]  type_byte;
    logic        light_frame;
    logic [31:0] stamp;
    logic [7:0]  payload [POS_PAYLOAD_BYTES] = '{default: 8'h00};

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Frame decoder: updates the parse state for one byte and queues the
    // record that byte completes, if any.
    task automatic parse_byte(input in_item_t it);
        out_item_t rec;
        bit        emit;
        int        need;
        rec  = '0;
        emit = 1'b0;
        case (parse_phase)
            PH_TYPE: begin
                type_byte = it.data_byte;
                stamp     = '0;
                field_idx = 0;
                if (it.buffer_end) begin
                    rec.status = ST_TRUNC;
                    emit       = 1'b1;
                end else begin
                    parse_phase = PH_TIME;
                end
            end
            PH_TIME: begin
                stamp[8*field_idx +: 8] = it.data_byte;
                field_idx++;
                if (field_idx == TIME_BYTES) begin
                    field_idx = 0;
                    if (type_byte == pos_code || type_byte == light_code) begin
                        light_frame = (type_byte != pos_code);
                        if (it.buffer_end) begin
                            parse_phase = PH_TYPE;
                            rec.status  = ST_TRUNC;
                            emit        = 1'b1;
                        end else begin
                            parse_phase = PH_PAYLOAD;
                        end
                    end else begin
                        parse_phase = it.buffer_end ? PH_TYPE : PH_DISCARD;
                        rec.status  = ST_UNKNOWN;
                        rec.time_ms = stamp;
                        emit        = 1'b1;
                    end
                end else if (it.buffer_end) begin
                    parse_phase = PH_TYPE;
                    rec.status  = ST_TRUNC;
                    emit        = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                need = light_frame ? LIGHT_PAYLOAD_BYTES : POS_PAYLOAD_BYTES;
                payload[field_idx] = it.data_byte;
                field_idx++;
                if (field_idx >= need) begin
                    parse_phase = PH_TYPE;
                    field_idx   = 0;
                    rec.time_ms = stamp;
                    emit        = 1'b1;
                    if (light_frame) begin
                        rec.status      = ST_LIGHT;
                        rec.light_index = payload[0];
                        rec.colour      = {payload[1], payload[2], payload[3]};
                    end else begin
                        rec.status = ST_POS;
                        rec.pos_x  = {payload[3], payload[2], payload[1], payload[0]};
                        rec.pos_y  = {payload[7], payload[6], payload[5], payload[4]};
                        rec.pos_z  = {payload[11], payload[10], payload[9], payload[8]};
                        rec.vel_x  = {payload[13], payload[12]};
                        rec.vel_y  = {payload[15], payload[14]};
                        rec.vel_z  = {payload[17], payload[16]};
                        rec.yaw    = {payload[19], payload[18]};
                    end
                end else if (it.buffer_end) begin
                    parse_phase = PH_TYPE;
                    field_idx   = 0;
                    rec.status  = ST_TRUNC;
                    emit        = 1'b1;
                end
            end
            default: begin
                if (it.buffer_end) begin
                    parse_phase = PH_TYPE;
                    field_idx   = 0;
                end
            end
        endcase
        if (emit) expected_records.push_back(rec);
    endtask

    task automatic check_field(input string fname, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= 10)
                $display("Mismatch in record %0d, %s: expected %h, actual %h",
                         n_records, fname, want, got);
        end
    endtask

    // Byte driver: a transaction stays on the bus until it is taken.
    always @(negedge aclk) begin
        if (!s_valid || n_taken == n_sent) begin
            if (byte_stream.size() != 0 && (no_idle || $urandom_range(0, 99) >= 11)) begin
                s_data  <= byte_stream.pop_front();
                s_valid <= 1'b1;
                n_sent++;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= no_idle || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && s_valid && s_ready) begin
            n_taken <= n_taken + 1;
            parse_byte(s_data);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("Unexpected record: status %0d time %h",
                             m_data.status, m_data.time_ms);
            end else begin
                want = expected_records.pop_front();
                check_field("status", 32'(m_data.status), 32'(want.status));
                check_field("time_ms", m_data.time_ms, want.time_ms);
                check_field("pos_x", m_data.pos_x, want.pos_x);
                check_field("pos_y", m_data.pos_y, want.pos_y);
                check_field("pos_z", m_data.pos_z, want.pos_z);
                check_field("vel_x", 32'(m_data.vel_x), 32'(want.vel_x));
                check_field("vel_y", 32'(m_data.vel_y), 32'(want.vel_y));
                check_field("vel_z", 32'(m_data.vel_z), 32'(want.vel_z));
                check_field("yaw", 32'(m_data.yaw), 32'(want.yaw));
                check_field("light_index", 32'(m_data.light_index),
                            32'(want.light_index));
                check_field("colour", 32'(m_data.colour), 32'(want.colour));
                status_count[want.status]++;
                n_records++;
            end
        end
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Timeout with %0d records outstanding", expected_records.size());
            $display("event_frame_parser verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] unknown_code();
        logic [7:0] c;
        do c = 8'($urandom); while (c == pos_code || c == light_code);
        return c;
    endfunction

    task automatic push_bytes(input logic [7:0] b[$], input bit end_last);
        in_item_t it;
        foreach (b[i]) begin
            it.data_byte  = b[i];
            it.buffer_end = end_last && (i == b.size() - 1);
            byte_stream.push_back(it);
            n_queued++;
        end
    endtask

    // Emits a frame with random content; a cut index ends the buffer early.
    task automatic add_frame(input logic [7:0] code, input int plen, input int cut,
                             input bit end_last);
        logic [7:0] fb[$];
        fb.push_back(code);
        repeat (TIME_BYTES + plen) fb.push_back(pick_byte());
        if (cut >= 0)
            while (fb.size() > cut + 1) void'(fb.pop_back());
        push_bytes(fb, end_last || cut >= 0);
    endtask

    task automatic add_buffer();
        int  frames;
        int  r;
        int  plen;
        logic [7:0] noise[$];
        frames = $urandom_range(1, 4);
        for (int f = 0; f < frames; f++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                add_frame(pos_code, POS_PAYLOAD_BYTES, -1, f == frames - 1);
            end else if (r < 75) begin
                add_frame(light_code, LIGHT_PAYLOAD_BYTES, -1, f == frames - 1);
            end else if (r < 85) begin
                add_frame(unknown_code(), $urandom_range(0, 6), -1, 1'b1);
                return;
            end else if (r < 95) begin
                plen = $urandom_range(0, 1) ? POS_PAYLOAD_BYTES : LIGHT_PAYLOAD_BYTES;
                add_frame($urandom_range(0, 1) ? pos_code : light_code, plen,
                          $urandom_range(0, TIME_BYTES + plen - 1), 1'b1);
                return;
            end else begin
                repeat ($urandom_range(1, 8)) noise.push_back(8'($urandom));
                push_bytes(noise, 1'b1);
                return;
            end
        end
    endtask

    task automatic drain();
        while (byte_stream.size() != 0 || s_valid || n_taken != n_sent ||
               expected_records.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_codes(input logic [7:0] pc, input logic [7:0] lc);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POSITION_CODE;
        cfg_wdata <= pc;
        @(negedge aclk);
        cfg_index <= CFG_LIGHT_CODE;
        cfg_wdata <= lc;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        pos_code   = pc;
        light_code = lc;
    endtask

    task automatic run_phase(input logic [7:0] pc, input logic [7:0] lc, input bit quiet);
        int start;
        drain();
        set_codes(pc, lc);
        @(posedge aclk);
        no_idle = quiet;
        start   = n_queued;
        while (n_queued - start < PHASE_BYTES) add_buffer();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_POSITION_CODE;
        cfg_wdata = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        @(posedge aclk);

        // Position frame at the field extremes, completed on the buffer end.
        push_bytes('{pos_code, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F,
                     8'h00, 8'h00, 8'hFF, 8'hFF}, 1'b1);
        // Unknown type whose last timestamp byte ends the buffer.
        push_bytes('{unknown_code(), 8'h5A, 8'hA5, 8'h3C, 8'hC3}, 1'b1);
        // A buffer holding only a type byte.
        push_bytes('{light_code}, 1'b1);
        while (n_queued < PHASE_BYTES) add_buffer();

        run_phase(8'h00, 8'hFF, 1'b1);
        run_phase(8'hFF, 8'h00, 1'b0);
        run_phase(8'h07, 8'h07, 1'b0);
        run_phase(8'($urandom), 8'($urandom), 1'b0);
        drain();
        repeat (20) @(negedge aclk);

        $display("Sent %0d bytes under five type code settings, checked %0d records:",
                 n_taken, n_records);
        $display("  %0d position, %0d light, %0d unknown type, %0d truncated",
                 status_count[ST_POS], status_count[ST_LIGHT],
                 status_count[ST_UNKNOWN], status_count[ST_TRUNC]);
        if (n_errors == 0) begin
            $display("event_frame_parser verification clean");
        end else begin
            $display("event_frame_parser verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/efp_pkg.sv
rtl/efp_frame_fsm.sv
rtl/efp_out_stage.sv
rtl/event_frame_parser.sv
dv/tb_top.sv
